// ===== rtl/csclip_pkg.sv =====
// csclip_pkg: shared constants and types for the line clipping core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package csclip_pkg;
    localparam int CoordWidth = 16;
    localparam int DiffWidth  = CoordWidth + 1;
    localparam int ProdWidth  = 2 * DiffWidth + 1;
    localparam int QuotWidth  = ProdWidth;
    localparam int MaxRounds  = 8;
    localparam int RoundWidth = 4;
    localparam int StepWidth  = 6;
    localparam int AddrWidth  = 4;

    typedef logic signed [CoordWidth-1:0] coord_t;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_BOTTOM = 2'd1;
    localparam logic [1:0] REG_RIGHT  = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    localparam logic [3:0] CODE_LEFT   = 4'b0001;
    localparam logic [3:0] CODE_RIGHT  = 4'b0010;
    localparam logic [3:0] CODE_BOTTOM = 4'b0100;
    localparam logic [3:0] CODE_TOP    = 4'b1000;

    localparam coord_t RST_LEFT   = -16'sd1600;
    localparam coord_t RST_BOTTOM = -16'sd1600;
    localparam coord_t RST_RIGHT  = 16'sd1600;
    localparam coord_t RST_TOP    = 16'sd1600;

    // outcode of one point against the window
    function automatic logic [3:0] outcode(coord_t x, coord_t y, coord_t l, coord_t b,
                                           coord_t r, coord_t t);
        logic [3:0] c;
        c = 4'b0000;
        if (x < l) c = c | CODE_LEFT;
        if (x > r) c = c | CODE_RIGHT;
        if (y < b) c = c | CODE_BOTTOM;
        if (y > t) c = c | CODE_TOP;
        return c;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/cohen_sutherland_line_clip_core.sv =====
// cohen_sutherland_line_clip_core: iterative outcode clipper with a shared
// multiplier and a one-bit-a-cycle restoring divider; depends on csclip_pkg
// a trivial accept or reject goes from the test straight to the output; each edge move
// runs setup, a multiply, 35 divider steps and an update, up to 8 moves
// throughput: one segment at a time; in_stall stays high until the result is taken
// the divider loop of one bit per cycle sets the cost of each edge move
// reset: asynchronous active low, window returns to -1600/1600, no segment pending
`timescale 1ns / 1ps
`default_nettype none
module cohen_sutherland_line_clip_core (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [csclip_pkg::AddrWidth-1:0]     paddr,
    input  wire [31:0]                          pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire signed [csclip_pkg::CoordWidth-1:0] start_x,
    input  wire signed [csclip_pkg::CoordWidth-1:0] start_y,
    input  wire signed [csclip_pkg::CoordWidth-1:0] end_x,
    input  wire signed [csclip_pkg::CoordWidth-1:0] end_y,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic                                visible,
    output logic signed [csclip_pkg::CoordWidth-1:0] clipped_start_x,
    output logic signed [csclip_pkg::CoordWidth-1:0] clipped_start_y,
    output logic signed [csclip_pkg::CoordWidth-1:0] clipped_end_x,
    output logic signed [csclip_pkg::CoordWidth-1:0] clipped_end_y
);
    import csclip_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_TEST = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_UPD  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    coord_t win_l_reg, win_b_reg, win_r_reg, win_t_reg;
    coord_t x1_reg, y1_reg, x2_reg, y2_reg;
    logic [3:0] c1_reg, c2_reg;
    logic [RoundWidth-1:0] round_reg;
    logic [StepWidth-1:0] step_reg;
    logic [ProdWidth-1:0] num_reg;     // shifts out dividend bits
    logic [ProdWidth-1:0] rem_reg;
    logic [QuotWidth-1:0] quot_reg;
    logic [DiffWidth:0] dvs_reg;       // 2*|den|
    logic neg_reg, zden_reg;
    logic signed [DiffWidth-1:0] ua_reg, un_reg; // magnitudes held signed-wide
    coord_t base_reg, edge_reg;
    logic move_y_reg;                  // edge is horizontal: new x interpolated

    // configuration port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb
    begin
        case (paddr[3:2])
            REG_LEFT:   prdata = 32'(win_l_reg);
            REG_BOTTOM: prdata = 32'(win_b_reg);
            REG_RIGHT:  prdata = 32'(win_r_reg);
            REG_TOP:    prdata = 32'(win_t_reg);
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_l_reg <= RST_LEFT;
            win_b_reg <= RST_BOTTOM;
            win_r_reg <= RST_RIGHT;
            win_t_reg <= RST_TOP;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_LEFT:   win_l_reg <= pwdata[CoordWidth-1:0];
                REG_BOTTOM: win_b_reg <= pwdata[CoordWidth-1:0];
                REG_RIGHT:  win_r_reg <= pwdata[CoordWidth-1:0];
                REG_TOP:    win_t_reg <= pwdata[CoordWidth-1:0];
                default:    win_l_reg <= win_l_reg;
            endcase
        end
    end

    // edge selection for the current round
    logic [3:0] csel;
    logic hit_top, hit_bot, hit_right;
    logic signed [DiffWidth-1:0] da, dn, dd;
    coord_t a1, b1, edge_sel;
    assign csel      = (c1_reg != 4'b0) ? c1_reg : c2_reg;
    assign hit_top   = (csel & CODE_TOP) != 4'b0;
    assign hit_bot   = (csel & CODE_BOTTOM) != 4'b0;
    assign hit_right = (csel & CODE_RIGHT) != 4'b0;
    always_comb
    begin
        if (hit_top || hit_bot)
        begin
            a1 = x1_reg;
            b1 = y1_reg;
            edge_sel = hit_top ? win_t_reg : win_b_reg;
            da = DiffWidth'(x2_reg) - DiffWidth'(x1_reg);
            dd = DiffWidth'(y2_reg) - DiffWidth'(y1_reg);
        end
        else
        begin
            a1 = y1_reg;
            b1 = x1_reg;
            edge_sel = hit_right ? win_r_reg : win_l_reg;
            da = DiffWidth'(y2_reg) - DiffWidth'(y1_reg);
            dd = DiffWidth'(x2_reg) - DiffWidth'(x1_reg);
        end
        dn = DiffWidth'(edge_sel) - DiffWidth'(b1);
    end

    // shared multiplier, registered into num_reg
    logic [2*DiffWidth-1:0] prod;
    assign prod = DiffWidth'(ua_reg) * DiffWidth'(un_reg);

    // divider step
    logic [ProdWidth-1:0] rem_sh;
    logic rem_ge;
    assign rem_sh = {rem_reg[ProdWidth-2:0], num_reg[ProdWidth-1]};
    assign rem_ge = rem_sh >= ProdWidth'(dvs_reg);

    // result of the move, rounded quotient added with sign and saturated
    logic signed [QuotWidth+1:0] moved_wide;
    coord_t moved;
    localparam logic signed [QuotWidth+1:0] LimHi = (QuotWidth+2)'(2**(CoordWidth-1) - 1);
    localparam logic signed [QuotWidth+1:0] LimLo = -(QuotWidth+2)'(2**(CoordWidth-1));
    always_comb
    begin
        moved_wide = neg_reg ? (QuotWidth+2)'(base_reg) - $signed({2'b00, quot_reg})
                             : (QuotWidth+2)'(base_reg) + $signed({2'b00, quot_reg});
        if (zden_reg) moved = base_reg;
        else if (moved_wide > LimHi) moved = LimHi[CoordWidth-1:0];
        else if (moved_wide < LimLo) moved = LimLo[CoordWidth-1:0];
        else moved = moved_wide[CoordWidth-1:0];
    end

    // sequencer
    logic accept_in, accept_out;
    assign accept_in  = in_valid && !in_stall;
    assign accept_out = out_valid && !out_stall;
    assign in_stall   = state_reg != ST_IDLE;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept_in) state_next = ST_TEST;
            ST_TEST:
            begin
                if ((c1_reg == 4'b0 && c2_reg == 4'b0) || (c1_reg & c2_reg) != 4'b0
                    || round_reg == RoundWidth'(MaxRounds))
                    state_next = ST_OUT;
                else
                    state_next = ST_MUL;
            end
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (step_reg == StepWidth'(ProdWidth - 1)) state_next = ST_UPD;
            ST_UPD:  state_next = ST_TEST;
            ST_OUT:  if (accept_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid <= (state_next == ST_OUT);
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                x1_reg <= start_x;
                y1_reg <= start_y;
                x2_reg <= end_x;
                y2_reg <= end_y;
                c1_reg <= outcode(start_x, start_y, win_l_reg, win_b_reg, win_r_reg, win_t_reg);
                c2_reg <= outcode(end_x, end_y, win_l_reg, win_b_reg, win_r_reg, win_t_reg);
                round_reg <= '0;
            end
            ST_TEST:
            begin
                visible <= (c1_reg == 4'b0 && c2_reg == 4'b0);
                if (c1_reg == 4'b0 && c2_reg == 4'b0)
                begin
                    clipped_start_x <= x1_reg;
                    clipped_start_y <= y1_reg;
                    clipped_end_x <= x2_reg;
                    clipped_end_y <= y2_reg;
                end
                else
                begin
                    clipped_start_x <= '0;
                    clipped_start_y <= '0;
                    clipped_end_x <= '0;
                    clipped_end_y <= '0;
                end
                ua_reg <= da[DiffWidth-1] ? -da : da;
                un_reg <= dn[DiffWidth-1] ? -dn : dn;
                dvs_reg <= {(dd[DiffWidth-1] ? -dd : dd), 1'b0};
                neg_reg <= da[DiffWidth-1] ^ dn[DiffWidth-1] ^ dd[DiffWidth-1];
                zden_reg <= dd == '0;
                base_reg <= a1;
                edge_reg <= edge_sel;
                move_y_reg <= hit_top || hit_bot;
            end
            ST_MUL:
            begin
                // 2N + D as dividend
                num_reg <= {prod, 1'b0} + ProdWidth'(dvs_reg[DiffWidth:1]);
                rem_reg <= '0;
                quot_reg <= '0;
                step_reg <= '0;
            end
            ST_DIV:
            begin
                num_reg <= {num_reg[ProdWidth-2:0], 1'b0};
                rem_reg <= rem_ge ? rem_sh - ProdWidth'(dvs_reg) : rem_sh;
                quot_reg <= {quot_reg[QuotWidth-2:0], rem_ge};
                step_reg <= step_reg + 1'b1;
            end
            ST_UPD:
            begin
                round_reg <= round_reg + 1'b1;
                if (c1_reg != 4'b0)
                begin
                    x1_reg <= move_y_reg ? moved : edge_reg;
                    y1_reg <= move_y_reg ? edge_reg : moved;
                    c1_reg <= move_y_reg
                        ? outcode(moved, edge_reg, win_l_reg, win_b_reg, win_r_reg, win_t_reg)
                        : outcode(edge_reg, moved, win_l_reg, win_b_reg, win_r_reg, win_t_reg);
                end
                else
                begin
                    x2_reg <= move_y_reg ? moved : edge_reg;
                    y2_reg <= move_y_reg ? edge_reg : moved;
                    c2_reg <= move_y_reg
                        ? outcode(moved, edge_reg, win_l_reg, win_b_reg, win_r_reg, win_t_reg)
                        : outcode(edge_reg, moved, win_l_reg, win_b_reg, win_r_reg, win_t_reg);
                end
            end
            default:
            begin
                round_reg <= round_reg;
            end
        endcase
    end

`ifndef SYNTH
    a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input open while result pending");
    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == ST_OUT) else $error("result outside output state");
    a_round_cap: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= RoundWidth'(MaxRounds)) else $error("round count overran");
    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPD |-> $past(state_reg) == ST_DIV) else $error("update without divide");
`endif
endmodule
`default_nettype wire

// ===== bench/cohen_sutherland_line_clip_core_tb.sv =====
// cohen_sutherland_line_clip_core_tb: self-checking bench for the line clipping core
// predicts each clipped segment in a scoreboard class; depends on csclip_pkg and the core
`timescale 1ns / 1ps
`default_nettype none
module cohen_sutherland_line_clip_core_tb;
    import csclip_pkg::*;

    typedef struct packed {
        logic   vis;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
    } clip_res_t;

    // window copy and clipped-segment predictor
    class clip_scoreboard;
        coord_t win_l, win_b, win_r, win_t;
        clip_res_t pending[$];
        int errors;
        int seen;
        int shown;

        function void set_window(logic [1:0] idx, coord_t v);
            case (idx)
                REG_LEFT:   win_l = v;
                REG_BOTTOM: win_b = v;
                REG_RIGHT:  win_r = v;
                default:    win_t = v;
            endcase
        endfunction

        function logic [3:0] region(longint x, longint y);
            logic [3:0] c;
            c = 4'b0000;
            if (x < win_l) c = c | CODE_LEFT;
            if (x > win_r) c = c | CODE_RIGHT;
            if (y < win_b) c = c | CODE_BOTTOM;
            if (y > win_t) c = c | CODE_TOP;
            return c;
        endfunction

        // a1 + round(da*num/den), ties away from zero
        function longint edge_cross(longint a1, longint a2, longint b1, longint b2,
                                    longint e);
            longint da, num, den, q, res;
            logic neg;
            da = a2 - a1;
            num = e - b1;
            den = b2 - b1;
            if (den == 0) return a1;
            neg = ((da < 0) ^ (num < 0) ^ (den < 0));
            if (da < 0) da = -da;
            if (num < 0) num = -num;
            if (den < 0) den = -den;
            q = (2 * da * num + den) / (2 * den);
            res = neg ? a1 - q : a1 + q;
            if (res > 32767) res = 32767;
            if (res < -32768) res = -32768;
            return res;
        endfunction

        function void note_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by);
            longint x1, y1, x2, y2, nx, ny;
            logic [3:0] c1, c2, c;
            logic ok;
            clip_res_t r;
            x1 = ax; y1 = ay; x2 = bx; y2 = by;
            c1 = region(x1, y1);
            c2 = region(x2, y2);
            ok = 1'b0;
            for (int rnd = 0; rnd <= MaxRounds; rnd++)
            begin
                if (c1 == 0 && c2 == 0)
                begin
                    ok = 1'b1;
                    break;
                end
                if ((c1 & c2) != 0 || rnd == MaxRounds) break;
                c = (c1 != 0) ? c1 : c2;
                if (c & CODE_TOP)
                begin
                    nx = edge_cross(x1, x2, y1, y2, win_t); ny = win_t;
                end
                else if (c & CODE_BOTTOM)
                begin
                    nx = edge_cross(x1, x2, y1, y2, win_b); ny = win_b;
                end
                else if (c & CODE_RIGHT)
                begin
                    ny = edge_cross(y1, y2, x1, x2, win_r); nx = win_r;
                end
                else
                begin
                    ny = edge_cross(y1, y2, x1, x2, win_l); nx = win_l;
                end
                if (c1 != 0)
                begin
                    x1 = nx; y1 = ny; c1 = region(x1, y1);
                end
                else
                begin
                    x2 = nx; y2 = ny; c2 = region(x2, y2);
                end
            end
            if (ok) r = '{1'b1, coord_t'(x1), coord_t'(y1), coord_t'(x2), coord_t'(y2)};
            else r = '0;
            pending.push_back(r);
        endfunction

        function void check_result(clip_res_t got);
            clip_res_t exp;
            seen++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected: %h", $time, got);
                return;
            end
            exp = pending.pop_front();
            if (exp != got)
            begin
                errors++;
                if (shown < 40)
                begin
                    shown++;
                    $display("%0t: mismatch expected vis=%0b %0d %0d %0d %0d",
                             $time, exp.vis, exp.sx, exp.sy, exp.ex, exp.ey);
                    $display("%0t:          actual   vis=%0b %0d %0d %0d %0d",
                             $time, got.vis, got.sx, got.sy, got.ex, got.ey);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AddrWidth-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    coord_t start_x = '0, start_y = '0, end_x = '0, end_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic visible;
    coord_t clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;
    int segments = 0;
    clip_scoreboard sb;

    always #5 clk = ~clk;

    cohen_sutherland_line_clip_core DUT (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .in_valid, .in_stall, .start_x, .start_y, .end_x, .end_y,
        .out_valid, .out_stall, .visible, .clipped_start_x, .clipped_start_y,
        .clipped_end_x, .clipped_end_y
    );

    // result checking and random receiver stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result('{visible, clipped_start_x, clipped_start_y,
                                  clipped_end_x, clipped_end_y});
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, coord_t v);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= AddrWidth'(4 * idx); pwdata <= 32'(unsigned'(v));
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_window(idx, v);
    endtask

    task automatic set_window(coord_t l, coord_t b, coord_t r, coord_t t);
        write_reg(REG_LEFT, l);
        write_reg(REG_BOTTOM, b);
        write_reg(REG_RIGHT, r);
        write_reg(REG_TOP, t);
    endtask

    // wait until every predicted result has arrived
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // the core stalls its input after each transfer until the result is taken, so the step to the
    // next edge before driving costs no throughput
    task automatic send_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by);
        @(posedge clk);
        while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        in_valid <= 1'b1;
        start_x <= ax; start_y <= ay; end_x <= bx; end_y <= by;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_segment(ax, ay, bx, by);
        segments++;
        in_valid <= 1'b0;
    endtask

    function automatic coord_t any_coord();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return coord_t'(16'sh7fff - $urandom_range(3));
        if (sel == 1) return coord_t'(-16'sh8000 + $urandom_range(3));
        if (sel < 5) return coord_t'($urandom);
        return coord_t'($signed($urandom_range(8000)) - 4000);
    endfunction

    task automatic random_segments(int n);
        for (int i = 0; i < n; i++)
            send_segment(any_coord(), any_coord(), any_coord(), any_coord());
    endtask

    initial
    begin
        sb = new();
        sb.win_l = RST_LEFT; sb.win_b = RST_BOTTOM;
        sb.win_r = RST_RIGHT; sb.win_t = RST_TOP;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cases on the reset window
        send_segment(0, 0, 100, 100);                // trivial accept
        send_segment(-2000, -2000, -1800, 2000);     // trivial reject, left
        send_segment(-3000, 0, 3000, 0);             // both ends outside, horizontal
        send_segment(0, -3000, 0, 3000);             // vertical through
        send_segment(0, 0, 0, 5000);                 // top edge
        send_segment(0, 0, 0, -5000);                // bottom edge
        send_segment(0, 0, 5000, 7);                 // right edge
        send_segment(0, 0, -5000, 3);                // left edge
        send_segment(-32768, -32768, 32767, 32767);  // full diagonal extremes
        send_segment(32767, -32768, -32768, 32767);
        send_segment(-1700, 1500, -1500, 1700);      // through the corner
        send_segment(-1600, -1600, 1600, 1600);      // on the edges
        send_segment(1601, 0, 1601, 0);              // point outside
        send_segment(3, -1999, 5, 1999);             // rounding
        drain();

        // extreme windows, inverted one included
        set_window(-32768, -32768, 32767, 32767);
        send_segment(-32768, 32767, 32767, -32768);
        send_segment(-32768, -32768, 32767, 32767);
        random_segments(40);
        drain();
        set_window(100, 100, -100, -100);
        send_segment(0, 0, 10, 10);
        send_segment(-500, 0, 500, 0);
        random_segments(40);
        drain();
        set_window(5, 5, 5, 5);
        send_segment(0, 0, 10, 10);
        random_segments(20);
        drain();

        // random phases with various idling patterns and windows
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            if (ph == 4) set_window(-1600, -1600, 1600, 1600);
            else begin
                coord_t a, b, c, d;
                a = coord_t'($signed($urandom_range(6000)) - 4000);
                b = coord_t'($signed($urandom_range(6000)) - 4000);
                c = a + coord_t'($urandom_range(6000));
                d = b + coord_t'($urandom_range(6000));
                set_window(a, b, c, d);
            end
            random_segments(75);
            drain();   // sender holds off until all results are back
            random_segments(75);
            drain();
        end

        $display("%0d segments clipped over %0d results, several windows and idle mixes",
                 segments, sb.seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/csclip_pkg.sv
rtl/cohen_sutherland_line_clip_core.sv
bench/cohen_sutherland_line_clip_core_tb.sv
